@@ rtl/core/a2otl_pkg.sv @@
// Shared types and default constants for the atan2 octant table lookup block.
// Depends on nothing; the top, front, back and table loader files refer to it by scoped names.
package a2otl_pkg;

  localparam int DEF_TABLE_STEPS     = 4096;
  localparam int DEF_ANGLE_FRAC_BITS = 16;
  localparam int DEF_COORD_WIDTH     = 24;

  // Quadrant code, encoded as {x negative, y negative}.
  typedef enum logic [1:0] {
    QUAD_1 = 2'b00,
    QUAD_4 = 2'b01,
    QUAD_2 = 2'b10,
    QUAD_3 = 2'b11
  } quad_t;

  // Folding information that travels with a request down the datapath.
  typedef struct packed {
    quad_t quad;
    logic  steep;
    logic  origin;
  } oct_info_t;

endpackage

@@ rtl/core/atan2_octant_table_lookup.sv @@
// Angle of a point (x, y) as a signed fixed-point number of radians.
// Uses: start takes a request when busy is low; in_x_value and in_y_value
// are sampled at that edge. Each result appears on out_angle for exactly one
// cycle, marked by out_valid, in the order the requests were taken.
// Path: a request passes the front register, the queue, the divider stages (one
// quotient bit each), the index register, the table read and the output
// register, in that order.
// Throughput: one request per cycle, sustained, once the table is loaded; busy stays low in normal use.
// The receiver cannot stall, so results are never held back.
// Reset (synchronous, rst_n low) empties the pipeline and the queue and starts
// the table load: a CORDIC unit computes the TABLE_STEPS+1 arctangent entries
// one after another. busy stays high until the whole table is written, and
// no request is taken meanwhile.
// The origin gives zero; equal magnitudes use the entry for atan(1).
// Depends on a2otl_pkg and the a2otl_* submodules.
module atan2_octant_table_lookup #(
  parameter int TABLE_STEPS     = a2otl_pkg::DEF_TABLE_STEPS,
  parameter int ANGLE_FRAC_BITS = a2otl_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int COORD_WIDTH     = a2otl_pkg::DEF_COORD_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     in_x_value,
  input  logic signed [COORD_WIDTH-1:0]     in_y_value,
  output logic                              out_valid,
  output logic signed [ANGLE_FRAC_BITS+2:0] out_angle
);

  localparam int QB  = $clog2(TABLE_STEPS + 1);
  localparam int FW  = 2 * COORD_WIDTH + $bits(a2otl_pkg::oct_info_t);
  localparam int LAT = QB + 6;

  logic                       accept;
  logic                       fill_done;
  logic                       front_push;
  logic                       front_stall;
  logic [COORD_WIDTH-1:0]     front_num;
  logic [COORD_WIDTH-1:0]     front_den;
  a2otl_pkg::oct_info_t       front_info;
  logic [FW-1:0]              q_wr_data;
  logic [FW-1:0]              q_rd_data;
  logic                       q_full;
  logic                       q_empty;
  logic                       rom_wr_en;
  logic [QB-1:0]              rom_wr_addr;
  logic [ANGLE_FRAC_BITS-1:0] rom_wr_data;
  logic [QB-1:0]              rom_rd_addr;
  logic [ANGLE_FRAC_BITS-1:0] rom_rd_data;

  assign busy      = !fill_done || front_stall;
  assign accept    = start && !busy;
  assign q_wr_data = {front_num, front_den, front_info};

  a2otl_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_x_value (in_x_value),
    .in_y_value (in_y_value),
    .fifo_full  (q_full),
    .push       (front_push),
    .stall      (front_stall),
    .num        (front_num),
    .den        (front_den),
    .info       (front_info)
  );

  a2otl_fifo #(
    .WIDTH (FW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (front_push),
    .wr_data (q_wr_data),
    .pop     (!q_empty),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  a2otl_rom_fill #(
    .TABLE_STEPS     (TABLE_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_fill (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rom_wr_en),
    .wr_addr (rom_wr_addr),
    .wr_data (rom_wr_data),
    .done    (fill_done)
  );

  a2otl_ram #(
    .WIDTH (ANGLE_FRAC_BITS),
    .DEPTH (TABLE_STEPS + 1)
  ) u_table (
    .clk     (clk),
    .wr_en   (rom_wr_en),
    .wr_addr (rom_wr_addr),
    .wr_data (rom_wr_data),
    .rd_addr (rom_rd_addr),
    .rd_data (rom_rd_data)
  );

  a2otl_back #(
    .COORD_WIDTH     (COORD_WIDTH),
    .TABLE_STEPS     (TABLE_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (!q_empty),
    .in_num    (q_rd_data[FW-1 -: COORD_WIDTH]),
    .in_den    (q_rd_data[FW-COORD_WIDTH-1 -: COORD_WIDTH]),
    .in_info   (a2otl_pkg::oct_info_t'(q_rd_data[$bits(a2otl_pkg::oct_info_t)-1:0])),
    .rd_addr   (rom_rd_addr),
    .rd_data   (rom_rd_data),
    .out_valid (out_valid),
    .out_angle (out_angle)
  );

`ifndef SYNTH
  a_no_result_during_load: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_done |-> !out_valid)
    else $error("result strobe while the table is still loading");

  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted request produced no result at the expected latency");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted request");

  a_origin_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_x_value == '0) && (in_y_value == '0) |-> ##LAT (out_angle == '0))
    else $error("origin did not give a zero angle");
`endif

endmodule

@@ rtl/core/a2otl_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module a2otl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/a2otl_fifo.sv @@
// Two-entry queue between the front and back halves of the atan2 block.
// Depends on nothing.
module a2otl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] data_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= wr_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/core/a2otl_front.sv @@
// Front half: takes a point, forms magnitudes, picks numerator and denominator
// and the octant information. Depends on a2otl_pkg.
module a2otl_front #(
  parameter int COORD_WIDTH = a2otl_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] in_x_value,
  input  logic signed [COORD_WIDTH-1:0] in_y_value,
  input  logic                          fifo_full,
  output logic                          push,
  output logic                          stall,
  output logic [COORD_WIDTH-1:0]        num,
  output logic [COORD_WIDTH-1:0]        den,
  output a2otl_pkg::oct_info_t          info
);

  logic                       x_neg;
  logic                       y_neg;
  logic [COORD_WIDTH-1:0]     mx;
  logic [COORD_WIDTH-1:0]     my;
  logic                       steep;
  a2otl_pkg::quad_t           quad;
  logic                       valid_r;
  logic [COORD_WIDTH-1:0]     num_r;
  logic [COORD_WIDTH-1:0]     den_r;
  a2otl_pkg::oct_info_t       info_r;

  // The magnitude of the most negative coordinate comes out exactly as an
  // unsigned value of the same width.
  always_comb begin
    x_neg = in_x_value[COORD_WIDTH-1];
    y_neg = in_y_value[COORD_WIDTH-1];
    mx    = x_neg ? (~in_x_value + COORD_WIDTH'(1)) : in_x_value;
    my    = y_neg ? (~in_y_value + COORD_WIDTH'(1)) : in_y_value;
    steep = !(my < mx);
    if (x_neg) begin
      quad = y_neg ? a2otl_pkg::QUAD_3 : a2otl_pkg::QUAD_2;
    end else begin
      quad = y_neg ? a2otl_pkg::QUAD_4 : a2otl_pkg::QUAD_1;
    end
  end

  assign push  = valid_r && !fifo_full;
  assign stall = valid_r && fifo_full;
  assign num   = num_r;
  assign den   = den_r;
  assign info  = info_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      num_r         <= steep ? mx : my;
      den_r         <= steep ? my : mx;
      info_r.quad   <= quad;
      info_r.steep  <= steep;
      info_r.origin <= (mx == '0) && (my == '0);
    end
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

endmodule

@@ rtl/core/a2otl_rom_fill.sv @@
// Table loader: after reset computes every arctangent entry with an iterative
// CORDIC unit and writes it into the table RAM. Depends on a2otl_pkg.
module a2otl_rom_fill #(
  parameter int TABLE_STEPS     = a2otl_pkg::DEF_TABLE_STEPS,
  parameter int ANGLE_FRAC_BITS = a2otl_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  output logic                               wr_en,
  output logic [$clog2(TABLE_STEPS+1)-1:0]   wr_addr,
  output logic [ANGLE_FRAC_BITS-1:0]         wr_data,
  output logic                               done
);

  localparam int AW    = $clog2(TABLE_STEPS + 1);
  localparam int ITERS = 50;
  localparam int IW    = $clog2(ITERS);
  localparam int XY_W  = 68;
  localparam int ZFRAC = 56;
  localparam int ZW    = 58;
  localparam int SH    = 64 - AW;

  typedef logic signed [ZW-1:0] angle_lut_t [ITERS];

  typedef enum logic [1:0] {
    FILL_LOAD,
    FILL_ITER,
    FILL_WRITE,
    FILL_DONE
  } fill_state_t;

  // Elementary angles atan(2^-k), worked out at elaboration.
  function automatic angle_lut_t build_lut();
    angle_lut_t lut;
    real        a;
    for (int k = 0; k < ITERS; k++) begin
      a      = $atan(2.0 ** (-k));
      lut[k] = ZW'(longint'(a * (2.0 ** ZFRAC)));
    end
    return lut;
  endfunction

  localparam angle_lut_t ATAN_LUT = build_lut();
  localparam logic signed [XY_W-1:0] X_START = XY_W'(TABLE_STEPS) << SH;

  fill_state_t              state_r;
  logic [AW-1:0]            idx_r;
  logic [IW-1:0]            iter_r;
  logic signed [XY_W-1:0]   x_r;
  logic signed [XY_W-1:0]   y_r;
  logic signed [ZW-1:0]     z_r;
  logic                     wr_en_r;
  logic [AW-1:0]            wr_addr_r;
  logic [ANGLE_FRAC_BITS-1:0] wr_data_r;
  logic                     done_r;
  logic signed [ZW-1:0]     z_rnd;
  logic signed [XY_W-1:0]   x_sh;
  logic signed [XY_W-1:0]   y_sh;

  always_comb begin
    z_rnd = z_r + (ZW'(1) << (ZFRAC - 1 - ANGLE_FRAC_BITS));
    x_sh  = x_r >>> iter_r;
    y_sh  = y_r >>> iter_r;
  end

  // Vectoring mode: the vector (TABLE_STEPS, index) is rotated onto the x axis
  // and the accumulated angle is its arctangent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FILL_LOAD;
      idx_r   <= '0;
      iter_r  <= '0;
      wr_en_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      wr_en_r <= 1'b0;
      case (state_r)
        FILL_LOAD: begin
          x_r     <= X_START;
          y_r     <= XY_W'(idx_r) << SH;
          z_r     <= '0;
          iter_r  <= '0;
          state_r <= FILL_ITER;
        end
        FILL_ITER: begin
          if (!y_r[XY_W-1]) begin
            x_r <= x_r + y_sh;
            y_r <= y_r - x_sh;
            z_r <= z_r + ATAN_LUT[iter_r];
          end else begin
            x_r <= x_r - y_sh;
            y_r <= y_r + x_sh;
            z_r <= z_r - ATAN_LUT[iter_r];
          end
          if (iter_r == IW'(ITERS - 1)) begin
            state_r <= FILL_WRITE;
          end else begin
            iter_r <= iter_r + IW'(1);
          end
        end
        FILL_WRITE: begin
          wr_en_r   <= 1'b1;
          wr_addr_r <= idx_r;
          wr_data_r <= z_rnd[ZFRAC-1:ZFRAC-ANGLE_FRAC_BITS];
          if (idx_r == AW'(TABLE_STEPS)) begin
            state_r <= FILL_DONE;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= FILL_LOAD;
          end
        end
        FILL_DONE: begin
          done_r <= 1'b1;
        end
        default: begin
          state_r <= FILL_LOAD;
        end
      endcase
    end
  end

  assign wr_en   = wr_en_r;
  assign wr_addr = wr_addr_r;
  assign wr_data = wr_data_r;
  assign done    = done_r;

endmodule

@@ rtl/core/a2otl_back.sv @@
// Back half: pipelined divider for the table index, round to nearest even,
// table read and octant folding. Depends on a2otl_pkg; reads the table RAM.
module a2otl_back #(
  parameter int COORD_WIDTH     = a2otl_pkg::DEF_COORD_WIDTH,
  parameter int TABLE_STEPS     = a2otl_pkg::DEF_TABLE_STEPS,
  parameter int ANGLE_FRAC_BITS = a2otl_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [COORD_WIDTH-1:0]            in_num,
  input  logic [COORD_WIDTH-1:0]            in_den,
  input  a2otl_pkg::oct_info_t              in_info,
  output logic [$clog2(TABLE_STEPS+1)-1:0]  rd_addr,
  input  logic [ANGLE_FRAC_BITS-1:0]        rd_data,
  output logic                              out_valid,
  output logic signed [ANGLE_FRAC_BITS+2:0] out_angle
);

  localparam int  MAG_W   = COORD_WIDTH;
  localparam int  QB      = $clog2(TABLE_STEPS + 1);
  localparam int  DW      = MAG_W + QB;
  localparam int  RW      = MAG_W + 1;
  localparam int  OUT_W   = ANGLE_FRAC_BITS + 3;
  localparam real PI_REAL = 3.14159265358979323846;
  localparam logic signed [OUT_W-1:0] PI_O =
    OUT_W'(longint'(PI_REAL * (2.0 ** ANGLE_FRAC_BITS)));
  localparam logic signed [OUT_W-1:0] HPI_O =
    OUT_W'(longint'(PI_REAL * (2.0 ** ANGLE_FRAC_BITS) / 2.0));

  typedef struct packed {
    logic [RW-1:0]        rem;
    logic [QB-1:0]        quo;
    logic [QB-1:0]        low;
    logic [MAG_W-1:0]     den;
    a2otl_pkg::oct_info_t info;
  } div_stage_t;

  div_stage_t               st_r   [QB+1];
  div_stage_t               st_nxt [QB+1];
  logic [QB:0]              vld_r;
  logic [DW-1:0]            prod;
  logic [RW-1:0]            trial  [QB];
  logic                     take   [QB];
  logic [RW:0]              rem2;
  logic [RW:0]              den_ext;
  logic                     round_up;
  logic [QB-1:0]            idx_nxt;
  logic [QB-1:0]            idx_r;
  a2otl_pkg::oct_info_t     info1_r;
  a2otl_pkg::oct_info_t     info2_r;
  logic                     vld1_r;
  logic                     vld2_r;
  logic signed [OUT_W-1:0]  t_ext;
  logic signed [OUT_W-1:0]  angle_nxt;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_angle_r;

  // The scaled quotient is below 2^QB, so the top bits of the dividend are
  // already below the divisor and only QB quotient bits remain to be found.
  always_comb begin
    prod = DW'(in_num) * DW'(TABLE_STEPS);
    st_nxt[0].rem  = RW'(prod[DW-1:QB]);
    st_nxt[0].quo  = '0;
    st_nxt[0].low  = prod[QB-1:0];
    st_nxt[0].den  = in_den;
    st_nxt[0].info = in_info;
    for (int k = 0; k < QB; k++) begin
      trial[k] = {st_r[k].rem[RW-2:0], st_r[k].low[QB-1]};
      take[k]  = (trial[k] >= RW'(st_r[k].den));
      st_nxt[k+1].rem  = take[k] ? (trial[k] - RW'(st_r[k].den)) : trial[k];
      st_nxt[k+1].quo  = {st_r[k].quo[QB-2:0], take[k]};
      st_nxt[k+1].low  = {st_r[k].low[QB-2:0], 1'b0};
      st_nxt[k+1].den  = st_r[k].den;
      st_nxt[k+1].info = st_r[k].info;
    end
  end

  // Round to nearest; an exact half goes to the even index.
  always_comb begin
    rem2     = {st_r[QB].rem, 1'b0};
    den_ext  = (RW + 1)'(st_r[QB].den);
    round_up = (rem2 > den_ext) || ((rem2 == den_ext) && st_r[QB].quo[0]);
    idx_nxt  = st_r[QB].quo + QB'(round_up);
  end

  always_comb begin
    t_ext = signed'(OUT_W'(rd_data));
    case (info2_r.quad)
      a2otl_pkg::QUAD_1: angle_nxt = info2_r.steep ? (HPI_O - t_ext) : t_ext;
      a2otl_pkg::QUAD_2: angle_nxt = info2_r.steep ? (HPI_O + t_ext) : (PI_O - t_ext);
      a2otl_pkg::QUAD_3: angle_nxt = info2_r.steep ? (-HPI_O - t_ext) : (t_ext - PI_O);
      a2otl_pkg::QUAD_4: angle_nxt = info2_r.steep ? (t_ext - HPI_O) : (-t_ext);
      default:           angle_nxt = '0;
    endcase
    if (info2_r.origin) begin
      angle_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    st_r        <= st_nxt;
    idx_r       <= idx_nxt;
    info1_r     <= st_r[QB].info;
    info2_r     <= info1_r;
    out_angle_r <= angle_nxt;
    if (!rst_n) begin
      vld_r       <= '0;
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[QB-1:0], in_valid};
      vld1_r      <= vld_r[QB];
      vld2_r      <= vld1_r;
      out_valid_r <= vld2_r;
    end
  end

  assign rd_addr   = idx_r;
  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

endmodule
